// File: src/tksi_pkg.sv
// ----------------------------------------------------------------------------
// tksi_pkg: shared types and constants for the top-k sorted insertion list
// Holds the stored entry layout, the sequencer states and register decode.
// ----------------------------------------------------------------------------
package tksi_pkg;

  localparam int unsigned ScoreW = 32;
  localparam int unsigned TagW   = 16;
  localparam int unsigned LimitW = 5;
  localparam int unsigned PosW   = 4;
  localparam int unsigned CountW = 5;
  localparam int unsigned AddrW  = 3;
  localparam int unsigned DataW  = 32;

  // register index taken from paddr[2]
  localparam logic RegKeepLimit = 1'b0;
  localparam logic [LimitW-1:0] KeepLimitReset = 5'd16;

  typedef struct packed {
    logic [ScoreW-1:0] score;
    logic [TagW-1:0]   tag;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_WRITE,
    ST_DONE
  } state_e;

endpackage

// File: src/tksi_rank_ram.sv
// ----------------------------------------------------------------------------
// tksi_rank_ram: rank store
// One write port and one registered read port, one entry per rank.
// ----------------------------------------------------------------------------
module tksi_rank_ram #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AW    = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  tksi_pkg::entry_t wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output tksi_pkg::entry_t rdata_o
);
  import tksi_pkg::*;

  entry_t mem_q [Depth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/top_k_sorted_insert_top.sv
// ----------------------------------------------------------------------------
// top_k_sorted_insert_top: top-k sorted insertion list
// Keeps the best scored entries in descending order with a shared comparator
// that walks the ranks from the lowest held entry upward.
// ----------------------------------------------------------------------------
// Sequence: each compared rank costs one registered store read (ST_READ)
// plus one compare-and-shift step (ST_CMP) in the shared unit; then ST_WRITE
// stores the entry, ST_DONE waits for the output register, then ST_IDLE.
// Reset: asynchronous active low; clears the count and the sequencer and sets
// keep_limit to 16. The rank store is not cleared; ranks past the count are
// never read.
module top_k_sorted_insert_top #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tksi_pkg::AddrW-1:0]   paddr,
  input  logic [tksi_pkg::DataW-1:0]   pwdata,
  output logic [tksi_pkg::DataW-1:0]   prdata,
  output logic                         pready,
  // request channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [tksi_pkg::ScoreW-1:0]  new_score_i,
  input  logic [tksi_pkg::TagW-1:0]    item_tag_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         accepted_o,
  output logic [tksi_pkg::PosW-1:0]    insert_position_o,
  output logic                         evicted_valid_o,
  output logic [tksi_pkg::TagW-1:0]    evicted_tag_o,
  output logic [tksi_pkg::CountW-1:0]  entry_count_o
);
  import tksi_pkg::*;

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam logic [6:0]  Cap7 = 7'(CAPACITY);

  function automatic logic [CntW-1:0] eff_limit(input logic [LimitW-1:0] k);
    logic [6:0] k7;
    k7 = 7'(k);
    if (k7 == 7'd0) begin
      k7 = 7'd1;
    end
    if (k7 > Cap7) begin
      k7 = Cap7;
    end
    return CntW'(k7);
  endfunction

  // configuration
  logic [LimitW-1:0] keep_limit_q;
  logic              cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == RegKeepLimit);
  assign prdata = (paddr[2] == RegKeepLimit) ? DataW'(keep_limit_q) : '0;

  // sequencer state
  state_e          state_q, state_d;
  logic [CntW-1:0] held_q, held_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] lim_q, lim_d;
  logic [CntW-1:0] hole_q, hole_d;
  logic [CntW-1:0] j_q, j_d;
  logic            full_q, full_d;
  logic            ev_q, ev_d;
  logic [TagW-1:0] ev_tag_q, ev_tag_d;
  entry_t          new_q, new_d;

  // result staging and output register
  logic            res_acc_q, res_acc_d;
  logic [CntW-1:0] res_pos_q, res_pos_d;
  logic [CntW-1:0] res_cnt_q, res_cnt_d;
  logic            out_valid_q, out_valid_d;
  logic            out_load;
  logic            out_acc_q;
  logic [6:0]      out_pos_q;
  logic            out_ev_q;
  logic [TagW-1:0] out_ev_tag_q;
  logic [6:0]      out_cnt_q;

  // rank store port
  logic            ram_we;
  logic [IdxW-1:0] ram_waddr;
  entry_t          ram_wdata;
  entry_t          ram_rdata;

  logic [CntW-1:0] start_count;
  logic [CntW-1:0] start_lim;
  logic [CntW-1:0] j_next;

  assign start_lim   = eff_limit(keep_limit_q);
  assign start_count = (held_q > start_lim) ? start_lim : held_q;
  assign j_next      = j_q + CntW'(1);

  tksi_rank_ram #(
    .Depth (CAPACITY),
    .AW    (IdxW)
  ) u_rank_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (j_q[IdxW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    held_d      = held_q;
    count_d     = count_q;
    lim_d       = lim_q;
    hole_d      = hole_q;
    j_d         = j_q;
    full_d      = full_q;
    ev_d        = ev_q;
    ev_tag_d    = ev_tag_q;
    new_d       = new_q;
    res_acc_d   = res_acc_q;
    res_pos_d   = res_pos_q;
    res_cnt_d   = res_cnt_q;
    out_valid_d = out_valid_q;
    out_load    = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = j_next[IdxW-1:0];
    ram_wdata   = ram_rdata;
    in_ready_o  = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          new_d.score = new_score_i;
          new_d.tag   = item_tag_i;
          count_d     = start_count;
          lim_d       = start_lim;
          full_d      = (start_count >= start_lim);
          hole_d      = start_count;
          j_d         = start_count - CntW'(1);
          ev_d        = 1'b0;
          ev_tag_d    = '0;
          state_d     = (start_count == '0) ? ST_WRITE : ST_READ;
        end
      end
      ST_READ: begin
        // store read of rank j is in flight
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (ram_rdata.score < new_q.score) begin
          hole_d = j_q;
          if (j_next < lim_q) begin
            // shift this entry one rank down
            ram_we = 1'b1;
          end else begin
            // lowest rank of a full list falls off
            ev_d     = 1'b1;
            ev_tag_d = ram_rdata.tag;
          end
          if (j_q == '0) begin
            state_d = ST_WRITE;
          end else begin
            j_d     = j_q - CntW'(1);
            state_d = ST_READ;
          end
        end else begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (full_q && (hole_q == count_q)) begin
          res_acc_d = 1'b0;
          res_pos_d = '0;
          res_cnt_d = count_q;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = hole_q[IdxW-1:0];
          ram_wdata = new_q;
          res_acc_d = 1'b1;
          res_pos_d = hole_q;
          res_cnt_d = full_q ? count_q : count_q + CntW'(1);
          held_d    = full_q ? count_q : count_q + CntW'(1);
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_we && (held_q > eff_limit(pwdata[LimitW-1:0]))) begin
      held_d = eff_limit(pwdata[LimitW-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      held_q       <= '0;
      keep_limit_q <= KeepLimitReset;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
      if (cfg_we) begin
        keep_limit_q <= pwdata[LimitW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    count_q   <= count_d;
    lim_q     <= lim_d;
    hole_q    <= hole_d;
    j_q       <= j_d;
    full_q    <= full_d;
    ev_q      <= ev_d;
    ev_tag_q  <= ev_tag_d;
    new_q     <= new_d;
    res_acc_q <= res_acc_d;
    res_pos_q <= res_pos_d;
    res_cnt_q <= res_cnt_d;
    if (out_load) begin
      out_acc_q    <= res_acc_q;
      out_pos_q    <= 7'(res_pos_q);
      out_ev_q     <= ev_q;
      out_ev_tag_q <= ev_tag_q;
      out_cnt_q    <= 7'(res_cnt_q);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign accepted_o        = out_acc_q;
  assign insert_position_o = out_pos_q[PosW-1:0];
  assign evicted_valid_o   = out_ev_q;
  assign evicted_tag_o     = out_ev_tag_q;
  assign entry_count_o     = out_cnt_q[CountW-1:0];

endmodule

// File: src/tksi_checker.sv
// ----------------------------------------------------------------------------
// tksi_checker: port-level checks for the top-k sorted insertion list
// Watches the request and result channels and the result field relations.
// ----------------------------------------------------------------------------
module tksi_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic                         accepted_o,
  input logic [tksi_pkg::PosW-1:0]    insert_position_o,
  input logic                         evicted_valid_o,
  input logic [tksi_pkg::TagW-1:0]    evicted_tag_o,
  input logic [tksi_pkg::CountW-1:0]  entry_count_o
);
  import tksi_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(accepted_o)
      && $stable(insert_position_o) && $stable(evicted_tag_o) && $stable(entry_count_o))
    else $error("result changed while stalled");

  // one request at a time
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready again right after a request");

  // a rejected request leaves no rank and evicts nothing
  a_reject_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !accepted_o |-> insert_position_o == '0 && !evicted_valid_o
      && entry_count_o != '0)
    else $error("bad fields on a rejected request");

  // evicted tag is zero unless an eviction happened, and eviction needs an insert
  a_evict_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (evicted_valid_o && accepted_o) || (!evicted_valid_o
      && evicted_tag_o == '0))
    else $error("bad eviction fields");

endmodule

bind top_k_sorted_insert_top tksi_checker u_tksi_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .accepted_o        (accepted_o),
  .insert_position_o (insert_position_o),
  .evicted_valid_o   (evicted_valid_o),
  .evicted_tag_o     (evicted_tag_o),
  .entry_count_o     (entry_count_o)
);

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the top-k sorted insertion list
// Streams scored entries through the request channel under several keep
// limits. It predicts each outcome from a local copy of the ranked store and
// checks every result field against it. Both sides idle at random, and a
// long receiver hold-off backs the block up.
// ----------------------------------------------------------------------------
module tb;
  import tksi_pkg::*;

  localparam int unsigned Cap         = 16;
  localparam int unsigned DrainCycles = 2 * Cap + 8;
  localparam int unsigned CycleLimit  = 1000000;
  localparam int unsigned PhaseItems  = 142;

  typedef struct packed {
    logic [ScoreW-1:0] score;
    logic [TagW-1:0]   tag;
  } request_t;

  typedef struct packed {
    logic              accepted;
    logic [PosW-1:0]   position;
    logic              ev_valid;
    logic [TagW-1:0]   ev_tag;
    logic [CountW-1:0] count;
  } outcome_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [AddrW-1:0]   paddr       = '0;
  logic [DataW-1:0]   pwdata      = '0;
  logic [DataW-1:0]   prdata;
  logic               pready;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic [ScoreW-1:0]  new_score_i = '0;
  logic [TagW-1:0]    item_tag_i  = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic               accepted_o;
  logic [PosW-1:0]    insert_position_o;
  logic               evicted_valid_o;
  logic [TagW-1:0]    evicted_tag_o;
  logic [CountW-1:0]  entry_count_o;

  top_k_sorted_insert_top #(.CAPACITY(Cap)) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .new_score_i      (new_score_i),
    .item_tag_i       (item_tag_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .accepted_o       (accepted_o),
    .insert_position_o(insert_position_o),
    .evicted_valid_o  (evicted_valid_o),
    .evicted_tag_o    (evicted_tag_o),
    .entry_count_o    (entry_count_o)
  );

  // local copy of the ranked store
  logic [ScoreW-1:0] rank_score_m[Cap];
  logic [TagW-1:0]   rank_tag_m[Cap];
  int unsigned       held_m;
  logic [LimitW-1:0] keep_limit_m;

  request_t    offer_q[$];
  outcome_t    outcome_q[$];
  request_t    cur_req;
  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;
  int unsigned offered      = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned send_gap     = 0;
  int unsigned stall_cnt    = 0;
  int unsigned hold_cnt     = 0;
  logic        holding      = 1'b0;
  logic        forced_hold  = 1'b0;
  logic        gaps_on      = 1'b1;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic int unsigned eff_limit(logic [LimitW-1:0] raw);
    int unsigned lim;
    lim = 32'(raw);
    if (lim < 1) lim = 1;
    if (lim > Cap) lim = Cap;
    return lim;
  endfunction

  function automatic outcome_t insert_entry(logic [ScoreW-1:0] score, logic [TagW-1:0] tag);
    outcome_t    res;
    int unsigned lim;
    int unsigned cnt;
    int unsigned pos;
    int unsigned newcnt;
    logic        found;
    res   = '0;
    found = 1'b0;
    lim   = eff_limit(keep_limit_m);
    cnt   = (held_m > lim) ? lim : held_m;
    pos   = cnt;
    for (int i = 0; i < Cap; i++) begin
      if (i < cnt && !found && rank_score_m[i] < score) begin
        pos   = i;
        found = 1'b1;
      end
    end
    if (pos < cnt) begin
      newcnt = cnt;
      if (cnt >= lim) begin
        res.ev_valid = 1'b1;
        res.ev_tag   = rank_tag_m[cnt-1];
      end else begin
        newcnt = cnt + 1;
      end
      // shift the lower ranks down by one
      for (int i = Cap - 1; i > 0; i--) begin
        if (i < newcnt && i > pos) begin
          rank_score_m[i] = rank_score_m[i-1];
          rank_tag_m[i]   = rank_tag_m[i-1];
        end
      end
      rank_score_m[pos] = score;
      rank_tag_m[pos]   = tag;
      cnt               = newcnt;
      res.accepted      = 1'b1;
      res.position      = PosW'(pos);
    end else if (cnt < lim) begin
      rank_score_m[cnt] = score;
      rank_tag_m[cnt]   = tag;
      res.position      = PosW'(cnt);
      cnt               = cnt + 1;
      res.accepted      = 1'b1;
    end
    held_m    = cnt;
    res.count = CountW'(cnt);
    return res;
  endfunction

  function automatic int unsigned pick_gap(logic on);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [ScoreW-1:0] pick_score();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0: return '0;
      1: return '1;
      2, 3, 4: return ScoreW'($urandom_range(0, 15));
      5: return ScoreW'($urandom_range(0, 1000));
      6: return '1 - ScoreW'($urandom_range(0, 7));
      default: return ScoreW'($urandom);
    endcase
  endfunction

  function automatic void offer(logic [ScoreW-1:0] score, logic [TagW-1:0] tag);
    request_t req;
    req.score = score;
    req.tag   = tag;
    offer_q.push_back(req);
    offered++;
  endfunction

  task automatic report(string field, longint unsigned want, longint unsigned got);
    if (mismatches < 100)
      $display("ERROR result %0d %s: expected 0x%0h got 0x%0h", results_seen, field, want, got);
    mismatches++;
  endtask

  task automatic write_limit(logic [DataW-1:0] value);
    int unsigned lim;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({RegKeepLimit, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    keep_limit_m = value[LimitW-1:0];
    lim = eff_limit(keep_limit_m);
    // a lowered limit silently drops the lowest entries
    if (held_m > lim) held_m = lim;
  endtask

  task automatic drain();
    // wait until every offered request has come back as a result
    while (offer_q.size() != 0 || in_valid_i || outcome_q.size() != 0 ||
           results_seen < offered) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // request driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) outcome_q.push_back(insert_entry(cur_req.score, cur_req.tag));
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (offer_q.size() != 0) begin
          cur_req = offer_q.pop_front();
          new_score_i <= cur_req.score;
          item_tag_i  <= cur_req.tag;
          in_valid_i  <= 1'b1;
          send_gap = pick_gap(gaps_on);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (outcome_q.size() == 0) begin
          report("unexpected result", 64'd0, 64'd1);
        end else begin
          want = outcome_q.pop_front();
          if (accepted_o !== want.accepted)
            report("accepted", 64'(want.accepted), 64'(accepted_o));
          if (insert_position_o !== want.position)
            report("insert_position", 64'(want.position), 64'(insert_position_o));
          if (evicted_valid_o !== want.ev_valid)
            report("evicted_valid", 64'(want.ev_valid), 64'(evicted_valid_o));
          if (evicted_tag_o !== want.ev_tag)
            report("evicted_tag", 64'(want.ev_tag), 64'(evicted_tag_o));
          if (entry_count_o !== want.count)
            report("entry_count", 64'(want.count), 64'(entry_count_o));
        end
        results_seen <= results_seen + 1;
      end
      if (stall_cnt > 0) stall_cnt--;
      else stall_cnt = pick_gap(gaps_on);
      out_ready_i <= !holding && stall_cnt == 0;
    end
  end

  // receiver hold-off: once early on, then now and again at random
  always @(posedge clk_i) begin
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      holding  <= hold_cnt > 1;
    end else if ((!forced_hold && results_seen >= 60) || $urandom_range(0, 2999) == 0) begin
      hold_cnt    <= $urandom_range(200, 400);
      holding     <= 1'b1;
      forced_hold <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("top_k_sorted_insert_top: mismatch");
      $finish;
    end
  end

  initial begin
    logic [LimitW-1:0] limits[12];
    held_m       = 0;
    keep_limit_m = KeepLimitReset;
    limits = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd17, 5'd3, 5'd16, 5'd8, 5'd2, 5'd15, 5'd0, 5'd0};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // small store: equal scores, fill, reject, evict
    write_limit(4);
    offer(32'd5, 16'h0000);
    offer(32'd5, 16'hFFFF);
    offer(32'hFFFF_FFFF, 16'h1111);
    offer(32'd0, 16'h2222);
    offer(32'd0, 16'h3333);
    offer(32'd3, 16'h4444);
    offer(32'hFFFF_FFFF, 16'h5555);
    offer(32'hFFFF_FFFF, 16'h6666);
    drain();
    // lower the limit below the count
    write_limit(2);
    offer(32'hFFFF_FFFF, 16'hAAAA);
    offer(32'd7, 16'h0001);
    drain();
    // zero acts as one
    write_limit(0);
    offer(32'hFFFF_FFFF, 16'h0002);
    offer(32'd0, 16'h0003);
    drain();
    // above capacity acts as capacity
    write_limit(31);
    offer(32'd0, 16'h0000);
    offer(32'd10, 16'hFFFF);
    offer(32'd10, 16'h1234);
    drain();
    write_limit(17);
    offer(32'd20, 16'h4321);
    offer(32'd0, 16'h8000);
    drain();

    for (int p = 0; p < 12; p++) begin
      if (p >= 10) write_limit($urandom_range(0, 31));
      else write_limit(DataW'(limits[p]));
      gaps_on = (p % 3) != 1;
      for (int n = 0; n < PhaseItems; n++) offer(pick_score(), TagW'($urandom_range(0, 65535)));
      drain();
    end

    if (mismatches == 0) begin
      $display("top_k_sorted_insert_top: match");
    end else begin
      $display("top_k_sorted_insert_top: mismatch");
    end
    $finish;
  end

endmodule
